// ===== src/cht_pkg.sv =====
`timescale 1ns / 1ps

package cht_pkg;

    localparam int MAX_BUCKETS = 64;
    localparam int WAYS        = 8;
    localparam int SLOTS       = MAX_BUCKETS * WAYS;

    localparam int BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int FILL_W = $clog2(WAYS + 1);
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NB_W   = 7;
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;
    localparam int CNT_W  = $clog2(KEY_W);

    localparam logic [NB_W-1:0] NB_RESET = NB_W'(64);

    localparam logic [OP_W-1:0] OP_PUT      = 2'd0;
    localparam logic [OP_W-1:0] OP_GET      = 2'd1;
    localparam logic [OP_W-1:0] OP_CONTAINS = 2'd2;
    localparam logic [OP_W-1:0] OP_REMOVE   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [BKT_W-1:0] bucket;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] read_value;
        logic [ST_W-1:0]  status;
    } rsp_t;

endpackage

// ===== src/cht_front.sv =====
`timescale 1ns / 1ps

module cht_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [cht_pkg::NB_W-1:0]  num_buckets,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [cht_pkg::OP_W-1:0]  in_op,
    input  logic [cht_pkg::KEY_W-1:0] in_key,
    input  logic [cht_pkg::VAL_W-1:0] in_value,
    output logic                      push,
    output cht_pkg::req_t             push_data,
    input  logic                      q_full
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [cht_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [cht_pkg::NB_W-1:0]   rem_reg, rem_next;
    logic [cht_pkg::NB_W-1:0]   div_reg, div_next;
    logic [cht_pkg::KEY_W-1:0]  sh_reg, sh_next;
    logic [cht_pkg::OP_W-1:0]   op_reg, op_next;
    logic [cht_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [cht_pkg::VAL_W-1:0]  val_reg, val_next;
    logic [cht_pkg::NB_W-1:0]   nb_eff;
    logic [cht_pkg::NB_W:0]     trial;

    always_comb begin
        nb_eff = num_buckets;
        if (num_buckets == '0) begin
            nb_eff = cht_pkg::NB_W'(1);
        end else if (num_buckets > cht_pkg::NB_W'(cht_pkg::MAX_BUCKETS)) begin
            nb_eff = cht_pkg::NB_W'(cht_pkg::MAX_BUCKETS);
        end
    end

    assign in_ready = (state_reg == F_IDLE);
    assign push     = (state_reg == F_PUSH) && !q_full;
    assign trial    = {rem_reg, sh_reg[cht_pkg::KEY_W-1]};

    always_comb begin
        push_data.op     = op_reg;
        push_data.key    = key_reg;
        push_data.value  = val_reg;
        push_data.bucket = cht_pkg::BKT_W'(rem_reg);
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        sh_next    = sh_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (in_valid) begin
                    op_next    = in_op;
                    key_next   = in_key;
                    val_next   = in_value;
                    sh_next    = in_key;
                    div_next   = nb_eff;
                    rem_next   = '0;
                    cnt_next   = '1;
                    state_next = F_DIV;
                end
            end
            F_DIV: begin
                if (trial >= {1'b0, div_reg}) begin
                    rem_next = cht_pkg::NB_W'(trial - {1'b0, div_reg});
                end else begin
                    rem_next = cht_pkg::NB_W'(trial);
                end
                sh_next  = {sh_reg[cht_pkg::KEY_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!q_full) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        sh_reg  <= sh_next;
        op_reg  <= op_next;
        key_reg <= key_next;
        val_reg <= val_next;
    end

endmodule

// ===== src/cht_queue.sv =====
`timescale 1ns / 1ps

module cht_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  cht_pkg::req_t push_data,
    output logic          full,
    input  logic          pop,
    output cht_pkg::req_t head,
    output logic          empty
);

    cht_pkg::req_t slot_reg [2];
    logic [1:0]    cnt_reg, cnt_next;
    logic          rd_reg, rd_next;
    logic          wr_reg, wr_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = slot_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        wr_next  = wr_reg;
        if (push) begin
            wr_next = ~wr_reg;
        end
        if (pop) begin
            rd_next = ~rd_reg;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
        if (push) begin
            slot_reg[wr_reg] <= push_data;
        end
    end

endmodule

// ===== src/cht_back.sv =====
`timescale 1ns / 1ps

module cht_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  cht_pkg::req_t q_head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output cht_pkg::rsp_t out_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILL = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_SHRD = 3'd4;
    localparam logic [2:0] S_SHWR = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [cht_pkg::KEY_W-1:0]  key_mem  [cht_pkg::SLOTS];
    logic [cht_pkg::VAL_W-1:0]  val_mem  [cht_pkg::SLOTS];
    logic [cht_pkg::FILL_W-1:0] fill_mem [cht_pkg::MAX_BUCKETS];

    logic [cht_pkg::MAX_BUCKETS-1:0] fv_reg, fv_next;
    logic [2:0]                 state_reg, state_next;
    cht_pkg::req_t              req_reg, req_next;
    logic [cht_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [cht_pkg::FILL_W-1:0] way_reg, way_next;
    cht_pkg::rsp_t              rsp_reg, rsp_next;
    logic                       ov_reg, ov_next;
    cht_pkg::rsp_t              od_reg, od_next;

    logic [cht_pkg::FILL_W-1:0] fill_rd;
    logic                       fv_rd;
    logic [cht_pkg::KEY_W-1:0]  key_rd;
    logic [cht_pkg::VAL_W-1:0]  val_rd;
    logic [cht_pkg::FILL_W-1:0] fill_eff;
    logic [cht_pkg::ADDR_W-1:0] base;
    logic [cht_pkg::ADDR_W-1:0] rd_addr;
    logic [cht_pkg::ADDR_W-1:0] wr_addr;
    logic                       mem_we;
    logic [cht_pkg::KEY_W-1:0]  wr_key;
    logic [cht_pkg::VAL_W-1:0]  wr_val;
    logic                       fill_we;
    logic [cht_pkg::FILL_W-1:0] fill_wdata;
    logic [cht_pkg::FILL_W-1:0] way_inc;

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign fill_eff  = fv_rd ? fill_rd : '0;
    assign base      = cht_pkg::ADDR_W'(req_reg.bucket) * cht_pkg::ADDR_W'(cht_pkg::WAYS);
    assign way_inc   = way_reg + 1'b1;
    assign pop       = (state_reg == S_IDLE) && !q_empty;

    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        fill_next  = fill_reg;
        way_next   = way_reg;
        rsp_next   = rsp_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        fv_next    = fv_reg;
        rd_addr    = base + cht_pkg::ADDR_W'(way_reg);
        wr_addr    = base + cht_pkg::ADDR_W'(way_reg);
        mem_we     = 1'b0;
        wr_key     = key_rd;
        wr_val     = val_rd;
        fill_we    = 1'b0;
        fill_wdata = fill_reg;
        if (ov_reg && out_ready) begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (!q_empty) begin
                    req_next   = q_head;
                    rsp_next   = '0;
                    way_next   = '0;
                    state_next = S_FILL;
                end
            end
            S_FILL: begin
                fill_next = fill_eff;
                if (req_reg.op == cht_pkg::OP_PUT) begin
                    if (fill_eff >= cht_pkg::FILL_W'(cht_pkg::WAYS)) begin
                        rsp_next.status = cht_pkg::ST_FULL;
                    end else begin
                        mem_we     = 1'b1;
                        wr_addr    = base + cht_pkg::ADDR_W'(fill_eff);
                        wr_key     = req_reg.key;
                        wr_val     = req_reg.value;
                        fill_we    = 1'b1;
                        fill_wdata = fill_eff + 1'b1;
                        fv_next[req_reg.bucket] = 1'b1;
                    end
                    state_next = S_DONE;
                end else if (fill_eff == '0) begin
                    rsp_next.status = cht_pkg::ST_MISS;
                    state_next      = S_DONE;
                end else begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if (key_rd == req_reg.key) begin
                    rsp_next.found = 1'b1;
                    if (req_reg.op == cht_pkg::OP_GET) begin
                        rsp_next.read_value = val_rd;
                    end
                    if (req_reg.op == cht_pkg::OP_REMOVE) begin
                        state_next = S_SHRD;
                    end else begin
                        state_next = S_DONE;
                    end
                end else begin
                    way_next = way_inc;
                    if (way_inc == fill_reg) begin
                        rsp_next.status = cht_pkg::ST_MISS;
                        state_next      = S_DONE;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            S_SHRD: begin
                rd_addr = base + cht_pkg::ADDR_W'(way_inc);
                if (way_inc < fill_reg) begin
                    state_next = S_SHWR;
                end else begin
                    fill_we    = 1'b1;
                    fill_wdata = fill_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SHWR: begin
                mem_we     = 1'b1;
                way_next   = way_inc;
                state_next = S_SHRD;
            end
            S_DONE: begin
                if (!ov_reg || out_ready) begin
                    ov_next    = 1'b1;
                    od_next    = rsp_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        key_rd  <= key_mem[rd_addr];
        val_rd  <= val_mem[rd_addr];
        fill_rd <= fill_mem[q_head.bucket];
        fv_rd   <= fv_reg[q_head.bucket];
        if (mem_we) begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
        if (fill_we) begin
            fill_mem[req_reg.bucket] <= fill_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            fv_reg    <= '0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            fv_reg    <= fv_next;
        end
        req_reg  <= req_next;
        fill_reg <= fill_next;
        way_reg  <= way_next;
        rsp_reg  <= rsp_next;
        od_reg   <= od_next;
    end

endmodule

// ===== src/chained_hash_table_engine.sv =====
`timescale 1ns / 1ps
// Chained hash table engine: key/value store, bucket = key mod num_buckets (0 taken as 1, above 64 as 64).
// Input channel s_*: one operation per item (put, get, contains, remove).
// Output channel m_*: exactly one result item per input item, in order.
// Configuration: cfg_wr_en/cfg_wr_data set num_buckets; write only when idle.
// Front: the bucket index comes from a bit-serial remainder unit; the front
// accepts an item, runs the division, then hands the request over and takes
// a new item only after that; a two-entry queue sits between front and back.
// Back: the fill count is read, then the stored ways are read and compared in
// turn (up to 8 ways); remove then shifts each later entry down by one slot.
// Put checks the fill count and writes the new entry at the end of the bucket.
// Results sit in an output register; a stalled receiver holds it, the back
// then waits, the queue fills and s_tready drops once the front is stuck.
// Reset (synchronous, aresetn low) empties the queue, marks every bucket
// empty and sets num_buckets to 64; stored keys are not cleared.

module chained_hash_table_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // operation[1:0], key[33:2], value[65:34], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // found[0], read_value[32:1], status[34:33], zero pad
);

    logic [cht_pkg::NB_W-1:0] nb_reg;
    logic                     push;
    cht_pkg::req_t            push_data;
    logic                     q_full;
    logic                     q_empty;
    logic                     pop;
    cht_pkg::req_t            q_head;
    cht_pkg::rsp_t            rsp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nb_reg <= cht_pkg::NB_RESET;
        end else if (cfg_wr_en) begin
            nb_reg <= cfg_wr_data;
        end
    end

    cht_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .num_buckets (nb_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tdata[1:0]),
        .in_key      (s_tdata[33:2]),
        .in_value    (s_tdata[65:34]),
        .push        (push),
        .push_data   (push_data),
        .q_full      (q_full)
    );

    cht_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    cht_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (rsp)
    );

    assign m_tdata = {5'd0, rsp.status, rsp.read_value, rsp.found};

`ifndef ASSERT_OFF
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && rsp.found |-> rsp.status == cht_pkg::ST_OK)
        else $error("found result with bad status");

    a_value_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && rsp.read_value != '0 |-> rsp.found)
        else $error("read value without hit");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !push)
        else $error("push into full queue");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> rsp.status <= cht_pkg::ST_FULL)
        else $error("illegal status");
`endif

endmodule
